/* rtl/udpt_pkg.sv */
// ----------------------------------------------------------------------------
// udpt_pkg
// Shared types and codes of the unacked delivery prefetch tracker.
// ----------------------------------------------------------------------------
package udpt_pkg;

   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 32;
   localparam int MAX_RESULTS = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PREFETCH_COUNT = 1'b0,
      CSR_PREFETCH_SIZE  = 1'b1
   } csr_idx_type;

   typedef enum logic [2:0] {
      CMD_PUSH      = 3'd0,
      CMD_PULL      = 3'd1,
      CMD_ACK       = 3'd2,
      CMD_REQUEUE   = 3'd3,
      CMD_REDELIVER = 3'd4
   } cmd_type;

   typedef enum logic [3:0] {
      ST_DELIVERED  = 4'd0,
      ST_BLOCKED    = 4'd1,
      ST_SKIPPED    = 4'd2,
      ST_ACKED      = 4'd3,
      ST_INVALID    = 4'd4,
      ST_REQUEUE    = 4'd5,
      ST_REDELIVER  = 4'd6,
      ST_EMPTY      = 4'd7,
      ST_FULL       = 4'd8
   } status_type;

   typedef struct packed {
      logic [2:0]  cmd;
      logic        ack_expected;
      logic [31:0] content_size;
      logic [7:0]  consumer_id;
      logic [7:0]  queue_id;
      logic        same_connection;
      logic [63:0] ack_tag;
      logic        ack_multiple;
   } req_type;

   typedef struct packed {
      logic [3:0]  status;
      logic [63:0] delivery_tag;
      logic [7:0]  out_consumer;
      logic [7:0]  out_queue;
      logic [31:0] out_size;
      logic        pulled;
      logic        last;
      logic        dispatch_request;
      logic [15:0] outstanding_count;
      logic [31:0] outstanding_bytes;
   } rsp_type;

   // one table entry
   typedef struct packed {
      logic [63:0] tag;
      logic [31:0] size;
      logic [7:0]  consumer;
      logic [7:0]  queue;
      logic        pull;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

/* rtl/udpt_ram.sv */
// ----------------------------------------------------------------------------
// udpt_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module udpt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

/* rtl/unacked_delivery_prefetch_tracker.sv */
// ----------------------------------------------------------------------------
// unacked_delivery_prefetch_tracker
// Ordered table of unacked deliveries with prefetch limits, kept in one RAM.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy low. Push and pull never
// raise busy: the result follows in the next cycle and a new command may be
// taken at once. Ack scans the table one entry per cycle through the RAM read
// port, shifts the tail down one entry per cycle, primes the read port again
// and recounts the totals one entry per cycle, keeping busy high throughout.
// Recover emits one entry per cycle on back-to-back cycles (at most 32) and
// keeps busy high while it walks. Ack and recover on an empty table answer in
// the next cycle without raising busy. Results appear for one cycle on
// rsp_valid and cannot be held off; the last result of a command carries
// rsp_data.last.
module unacked_delivery_prefetch_tracker
   import udpt_pkg::*;
#(
   parameter int TABLE_DEPTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_idx,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);
   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_SHIFT, S_PRIME, S_RECOUNT, S_WALK, S_DONE
   } state_type;

   state_type   state_ff;
   req_type     req_ff;
   logic [15:0] pf_count_ff;
   logic [31:0] pf_size_ff;
   logic [63:0] next_tag_ff;
   logic [CW-1:0] count_ff;
   logic [15:0] pend_cnt_ff;
   logic [31:0] pend_bytes_ff;
   logic [CW-1:0] ptr_ff;      // address issued this cycle
   logic          rd_vld_ff;   // read data valid this cycle
   logic [CW-1:0] rd_idx_ff;   // index of read data
   logic [CW-1:0] n_ff;
   logic [16:0]   rc_cnt_ff;
   logic [32:0]   rc_bytes_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_ff;

   logic            wr_en;
   logic [AW-1:0]   wr_addr, rd_addr;
   entry_type       wr_data, rd_entry;
   logic [ENTRY_W-1:0] rd_raw;

   assign rd_entry = entry_type'(rd_raw);

   udpt_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   logic [32:0] size_sum;
   logic        cnt_ok, sz_ok, full;
   assign size_sum = {1'b0, req_data.content_size} + {1'b0, pend_bytes_ff};
   assign cnt_ok = (pf_count_ff == '0) || ({{(16-CW){1'b0}}, count_ff} < pf_count_ff);
   assign sz_ok  = (pf_size_ff == '0) || (count_ff == '0) ||
                   ({1'b0, pf_size_ff} > size_sum);
   assign full   = (count_ff == CW'(TABLE_DEPTH));

   // totals after a delivered push or pull
   logic        push_rec;
   logic [15:0] dlv_cnt;
   logic [31:0] dlv_bytes;
   assign push_rec  = req_data.ack_expected && (req_data.cmd == CMD_PUSH);
   assign dlv_cnt   = (push_rec && pend_cnt_ff != 16'hFFFF) ? pend_cnt_ff + 16'd1
                                                            : pend_cnt_ff;
   assign dlv_bytes = !push_rec ? pend_bytes_ff :
                      size_sum[32] ? 32'hFFFFFFFF : size_sum[31:0];

   // entries emitted by a recover walk
   logic [CW-1:0] walk_n;
   assign walk_n = (int'(count_ff) > MAX_RESULTS) ? CW'(MAX_RESULTS) : count_ff;

   // combinational RAM control
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = count_ff[AW-1:0];
      wr_data = '{tag: next_tag_ff, size: req_data.content_size,
                  consumer: req_data.consumer_id, queue: req_data.queue_id,
                  pull: (req_data.cmd == CMD_PULL)};
      rd_addr = ptr_ff[AW-1:0];
      if (state_ff == S_IDLE && start && req_data.ack_expected && !full &&
          ((req_data.cmd == CMD_PULL) ||
           (req_data.cmd == CMD_PUSH && !req_data.same_connection &&
            cnt_ok && sz_ok))) begin
         wr_en = 1'b1;
      end
      if (state_ff == S_SHIFT && rd_vld_ff) begin
         wr_en   = 1'b1;
         wr_addr = AW'(rd_idx_ff - n_ff);
         wr_data = rd_entry;
      end
      if (state_ff == S_IDLE) begin
         rd_addr = '0;
      end
   end

   function automatic rsp_type mk(input logic [3:0] st, input logic [63:0] tag,
                                  input logic [7:0] cons, input logic [7:0] q,
                                  input logic [31:0] sz, input logic pl,
                                  input logic lst, input logic disp,
                                  input logic [15:0] pc, input logic [31:0] pb);
      rsp_type r;
      r = '0;
      r.status = st;
      r.delivery_tag = tag;
      r.out_consumer = cons;
      r.out_queue = q;
      r.out_size = sz;
      r.pulled = pl;
      r.last = lst;
      r.dispatch_request = disp;
      r.outstanding_count = pc;
      r.outstanding_bytes = pb;
      return r;
   endfunction

   logic [16:0] rc_cnt_nx;
   logic [32:0] rc_bytes_nx;
   always_comb begin
      rc_cnt_nx   = rc_cnt_ff;
      rc_bytes_nx = rc_bytes_ff;
      if (!rd_entry.pull) begin
         rc_cnt_nx   = rc_cnt_ff + 17'd1;
         rc_bytes_nx = rc_bytes_ff + {1'b0, rd_entry.size};
      end
      if (rc_cnt_nx[16])   rc_cnt_nx   = 17'h0FFFF;
      if (rc_bytes_nx[32]) rc_bytes_nx = 33'h0FFFFFFFF;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pf_count_ff   <= '0;
         pf_size_ff    <= '0;
         next_tag_ff   <= 64'd1;
         count_ff      <= '0;
         pend_cnt_ff   <= '0;
         pend_bytes_ff <= '0;
         ptr_ff        <= '0;
         rd_vld_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_idx_type'(csr_idx))
               CSR_PREFETCH_COUNT: pf_count_ff <= csr_wdata[15:0];
               CSR_PREFETCH_SIZE:  pf_size_ff  <= csr_wdata;
               default: ;
            endcase
         end
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  req_ff <= req_data;
                  case (req_data.cmd)
                     CMD_PUSH, CMD_PULL: begin
                        rsp_valid_ff <= 1'b1;
                        if (req_data.cmd == CMD_PUSH && req_data.same_connection) begin
                           rsp_ff <= mk(ST_SKIPPED, '0, '0, '0, '0, 1'b0, 1'b1, 1'b0,
                                        pend_cnt_ff, pend_bytes_ff);
                        end else if (req_data.cmd == CMD_PUSH &&
                                     req_data.ack_expected && !(cnt_ok && sz_ok)) begin
                           rsp_ff <= mk(ST_BLOCKED, '0, '0, '0, '0, 1'b0, 1'b1, 1'b0,
                                        pend_cnt_ff, pend_bytes_ff);
                        end else if (req_data.ack_expected && full) begin
                           rsp_ff <= mk(ST_FULL, '0, '0, '0, '0, 1'b0, 1'b1, 1'b0,
                                        pend_cnt_ff, pend_bytes_ff);
                        end else begin
                           next_tag_ff <= next_tag_ff + 64'd1;
                           rsp_ff <= mk(ST_DELIVERED, next_tag_ff, req_data.consumer_id,
                                        req_data.queue_id, req_data.content_size,
                                        (req_data.cmd == CMD_PULL), 1'b1, 1'b0,
                                        dlv_cnt, dlv_bytes);
                           // recount equals running total plus this entry
                           pend_cnt_ff   <= dlv_cnt;
                           pend_bytes_ff <= dlv_bytes;
                           if (req_data.ack_expected) begin
                              count_ff <= count_ff + CW'(1);
                           end
                        end
                     end
                     CMD_ACK: begin
                        if (count_ff == '0) begin
                           rsp_valid_ff <= 1'b1;
                           rsp_ff <= mk(ST_INVALID, req_data.ack_tag, '0, '0, '0, 1'b0,
                                        1'b1, 1'b0, pend_cnt_ff, pend_bytes_ff);
                        end else begin
                           rsp_valid_ff <= 1'b0;
                           state_ff  <= S_SCAN;
                           ptr_ff    <= CW'(1);
                           rd_vld_ff <= 1'b1;
                           rd_idx_ff <= '0;
                        end
                     end
                     CMD_REQUEUE, CMD_REDELIVER: begin
                        if (req_data.cmd == CMD_REQUEUE) begin
                           pend_cnt_ff   <= '0;
                           pend_bytes_ff <= '0;
                        end
                        if (count_ff == '0) begin
                           rsp_valid_ff <= 1'b1;
                           rsp_ff <= mk(ST_EMPTY, '0, '0, '0, '0, 1'b0, 1'b1, 1'b0,
                              (req_data.cmd == CMD_REQUEUE) ? 16'd0 : pend_cnt_ff,
                              (req_data.cmd == CMD_REQUEUE) ? 32'd0 : pend_bytes_ff);
                        end else begin
                           rsp_valid_ff <= 1'b0;
                           state_ff  <= S_WALK;
                           ptr_ff    <= CW'(1);
                           rd_vld_ff <= 1'b1;
                           rd_idx_ff <= '0;
                        end
                     end
                     default: rsp_valid_ff <= 1'b0;
                  endcase
               end else begin
                  rsp_valid_ff <= 1'b0;
               end
            end
            S_SCAN: begin
               if (rd_entry.tag == req_ff.ack_tag) begin
                  rsp_valid_ff <= 1'b0;
                  n_ff  <= req_ff.ack_multiple ? rd_idx_ff + CW'(1) : CW'(1);
                  // restart reads after the match
                  ptr_ff    <= rd_idx_ff + CW'(2);
                  rd_idx_ff <= rd_idx_ff + CW'(1);
                  rd_vld_ff <= (rd_idx_ff + CW'(1) < count_ff);
                  state_ff  <= S_SHIFT;
               end else if (rd_idx_ff + CW'(1) >= count_ff) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff <= mk(ST_INVALID, req_ff.ack_tag, '0, '0, '0, 1'b0, 1'b1, 1'b0,
                               pend_cnt_ff, pend_bytes_ff);
                  state_ff <= S_IDLE;
               end else begin
                  rsp_valid_ff <= 1'b0;
                  ptr_ff    <= ptr_ff + CW'(1);
                  rd_idx_ff <= rd_idx_ff + CW'(1);
               end
            end
            S_SHIFT: begin
               rsp_valid_ff <= 1'b0;
               if (rd_vld_ff && (rd_idx_ff + CW'(1) < count_ff)) begin
                  ptr_ff    <= ptr_ff + CW'(1);
                  rd_idx_ff <= rd_idx_ff + CW'(1);
               end else begin
                  count_ff <= count_ff - n_ff;
                  ptr_ff   <= '0;
                  state_ff <= S_PRIME;
               end
            end
            S_PRIME: begin
               // last shifted entry is written; read entry 0 again
               rsp_valid_ff <= 1'b0;
               rc_cnt_ff    <= '0;
               rc_bytes_ff  <= '0;
               ptr_ff       <= CW'(1);
               rd_idx_ff    <= '0;
               rd_vld_ff    <= (count_ff != '0);
               state_ff     <= S_RECOUNT;
            end
            S_RECOUNT: begin
               // rd_addr reads ptr while rd_entry shows rd_idx
               if (!rd_vld_ff) begin
                  pend_cnt_ff   <= rc_cnt_ff[15:0];
                  pend_bytes_ff <= rc_bytes_ff[31:0];
                  rsp_valid_ff  <= 1'b1;
                  rsp_ff <= mk(ST_ACKED, req_ff.ack_tag, '0, '0, '0, 1'b0, 1'b1, 1'b1,
                               rc_cnt_ff[15:0], rc_bytes_ff[31:0]);
                  state_ff <= S_IDLE;
               end else begin
                  rsp_valid_ff <= 1'b0;
                  rc_cnt_ff   <= rc_cnt_nx;
                  rc_bytes_ff <= rc_bytes_nx;
                  ptr_ff      <= ptr_ff + CW'(1);
                  rd_idx_ff   <= rd_idx_ff + CW'(1);
                  rd_vld_ff   <= (rd_idx_ff + CW'(1) < count_ff);
               end
            end
            S_WALK: begin
               rsp_valid_ff <= 1'b1;
               rsp_ff <= mk((req_ff.cmd == CMD_REQUEUE || rd_entry.pull) ?
                            ST_REQUEUE : ST_REDELIVER, rd_entry.tag,
                            rd_entry.consumer, rd_entry.queue, rd_entry.size,
                            rd_entry.pull, (rd_idx_ff + CW'(1) >= walk_n), 1'b0,
                            pend_cnt_ff, pend_bytes_ff);
               if (rd_idx_ff + CW'(1) >= walk_n) begin
                  if (req_ff.cmd == CMD_REQUEUE) count_ff <= '0;
                  state_ff <= S_DONE;
               end else begin
                  ptr_ff    <= ptr_ff + CW'(1);
                  rd_idx_ff <= rd_idx_ff + CW'(1);
               end
            end
            S_DONE: begin
               rsp_valid_ff <= 1'b0;
               state_ff <= S_IDLE;
            end
            default: begin
               rsp_valid_ff <= 1'b0;
               state_ff <= S_IDLE;
            end
         endcase
      end
   end
endmodule

/* rtl/udpt_checker.sv */
// ----------------------------------------------------------------------------
// udpt_checker
// Port-level checks of the prefetch tracker, bound to the top level.
// ----------------------------------------------------------------------------
module udpt_checker
   import udpt_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_data
);
   a_busy_after_reset: assert property (@(posedge clock) reset |=> !busy)
      else $error("busy after reset");
   a_dispatch_acked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.dispatch_request |-> rsp_data.status == ST_ACKED)
      else $error("dispatch without ack");
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !busy |-> rsp_data.last)
      else $error("idle with open transfer");
   a_walk_cont: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |=> rsp_valid)
      else $error("gap in recover walk");
   a_rsp_needs_start: assert property (@(posedge clock) disable iff (reset)
      !busy && !start |=> !rsp_valid)
      else $error("response without transfer");
endmodule

bind unacked_delivery_prefetch_tracker udpt_checker u_udpt_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_data(rsp_data)
);
